/* src/packbits_run_length_encoder_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros for the packbits encoder
// ---------------------------------------------------------------------------
`ifndef PACKBITS_RUN_LENGTH_ENCODER_MACROS_SVH
`define PACKBITS_RUN_LENGTH_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
// property sampled on the rising clock, off while reset is held
`define PRLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("prle assertion failed");
// same-cycle implication
`define PRLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("prle implication failed");
`else
`define PRLE_ASSERT(lbl, clk, rstn, prop)
`define PRLE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

/* src/prle_pkg.sv */
// ---------------------------------------------------------------------------
// prle_pkg
// shared constants, emit selects and controller/datapath interface structs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prle_pkg;

  localparam int MaxLiteralDef = 32;
  localparam int MaxRunDef     = 128;

  // end-of-stream marker and run header base (257 mod 256)
  localparam logic [7:0] MarkByte = 8'd128;
  localparam logic [7:0] RunBase  = 8'd1;

  typedef enum logic [2:0] {
    SEL_RUN_HDR,
    SEL_RUN_DATA,
    SEL_LIT_HDR,
    SEL_LIT_DATA,
    SEL_MARK
  } emit_sel_e;

  typedef struct packed {
    logic      latch;      // capture the input request
    logic      load;       // held byte takes the captured byte, count one
    logic      inc;        // count one more repeat
    logic      clr;        // drop the held byte
    logic      push;       // append held byte to the literal store
    logic      emit;       // write one code byte to the output register
    emit_sel_e sel;
    logic      item_done;
  } prle_cmd_t;

  typedef struct packed {
    logic held_valid;
    logic eq;          // captured byte equals held byte
    logic cnt_ge2;     // held byte already forms a run
    logic cnt_full;    // one more repeat reaches the run limit
    logic lit_nz;      // literal bytes pending
    logic push_full;   // a push now fills the store
    logic lit_last;    // read pointer on the last pending literal byte
    logic fin;         // captured request ends the stream
    logic out_free;    // output register can take a byte this cycle
  } prle_sts_t;

endpackage

/* src/prle_dp.sv */
// ---------------------------------------------------------------------------
// prle_dp
// datapath: held byte, repeat count, literal store memory and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packbits_run_length_encoder_macros.svh"

module prle_dp #(
  parameter int MAX_LITERAL = prle_pkg::MaxLiteralDef,
  parameter int MAX_RUN     = prle_pkg::MaxRunDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  input  prle_pkg::prle_cmd_t cmd_i,
  output prle_pkg::prle_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          code_byte_o,
  output logic                item_done_o,
  output logic                stream_done_o
);
  import prle_pkg::*;

  localparam int LitCntW = $clog2(MAX_LITERAL + 1);
  localparam int IdxW    = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
  localparam int RunCntW = $clog2(MAX_RUN + 1);

  logic [7:0]         b_q;
  logic               fin_q;
  logic [7:0]         held_q;
  logic               valid_q;
  logic [RunCntW-1:0] cnt_q;
  logic [LitCntW-1:0] lit_cnt_q;
  logic [IdxW-1:0]    idx_q;
  logic [7:0]         mem [MAX_LITERAL];
  logic [7:0]         rd_q;
  logic [IdxW-1:0]    rd_addr;
  logic               out_valid_q;
  logic [7:0]         code_q;
  logic               item_done_q;
  logic               stream_done_q;
  logic [7:0]         code_d;
  logic               lit_emit;

  assign lit_emit = cmd_i.emit && (cmd_i.sel == SEL_LIT_DATA);

  always_comb begin
    sts_o.held_valid = valid_q;
    sts_o.eq         = (b_q == held_q);
    sts_o.cnt_ge2    = (cnt_q >= RunCntW'(2));
    sts_o.cnt_full   = (cnt_q >= RunCntW'(MAX_RUN - 1));
    sts_o.lit_nz     = (lit_cnt_q != '0);
    sts_o.push_full  = (lit_cnt_q == LitCntW'(MAX_LITERAL - 1));
    sts_o.lit_last   = ((LitCntW'(idx_q) + LitCntW'(1)) == lit_cnt_q);
    sts_o.fin        = fin_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // advance the read pointer only when a literal byte leaves
  assign rd_addr = lit_emit ? (idx_q + IdxW'(1)) : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[lit_cnt_q[IdxW-1:0]] <= held_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_RUN_HDR:  code_d = RunBase - 8'(cnt_q);
      SEL_RUN_DATA: code_d = held_q;
      SEL_LIT_HDR:  code_d = 8'(lit_cnt_q) - 8'd1;
      SEL_LIT_DATA: code_d = rd_q;
      SEL_MARK:     code_d = MarkByte;
      default:      code_d = MarkByte;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      b_q   <= data_byte_i;
      fin_q <= final_byte_i;
    end
    if (cmd_i.emit) begin
      code_q        <= code_d;
      item_done_q   <= cmd_i.item_done;
      stream_done_q <= (cmd_i.sel == SEL_MARK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      valid_q     <= 1'b0;
      cnt_q       <= '0;
      lit_cnt_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        held_q  <= b_q;
        valid_q <= 1'b1;
        cnt_q   <= RunCntW'(1);
      end else if (cmd_i.clr) begin
        held_q  <= '0;
        valid_q <= 1'b0;
        cnt_q   <= '0;
      end else if (cmd_i.inc) begin
        cnt_q <= cnt_q + RunCntW'(1);
      end
      if (cmd_i.push) begin
        lit_cnt_q <= lit_cnt_q + LitCntW'(1);
      end else if (lit_emit) begin
        if (sts_o.lit_last) begin
          lit_cnt_q <= '0;
          idx_q     <= '0;
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_byte_o   = code_q;
  assign item_done_o   = item_done_q;
  assign stream_done_o = stream_done_q;

  `PRLE_ASSERT(a_held_has_count, clk_i, rst_ni, !valid_q || (cnt_q != '0))
  `PRLE_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, cmd_i.push, lit_cnt_q < LitCntW'(MAX_LITERAL))
  `PRLE_ASSERT_IMP(a_mark_byte, clk_i, rst_ni, out_valid_q && stream_done_q, (code_q == MarkByte) && item_done_q)

endmodule

/* src/prle_ctrl.sv */
// ---------------------------------------------------------------------------
// prle_ctrl
// sequencer: walks one request through literal, run, flush and end-of-stream steps
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packbits_run_length_encoder_macros.svh"

module prle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prle_pkg::prle_sts_t sts_i,
  output prle_pkg::prle_cmd_t cmd_o
);
  import prle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_INC,
    S_FIN,
    S_FLUSH,
    S_RUN_HDR,
    S_RUN_DATA,
    S_LIT_HDR,
    S_LIT_DATA,
    S_MARK
  } state_e;

  // where a run or literal packet returns to
  typedef enum logic [2:0] {
    R_LOAD,
    R_CLR,
    R_INC,
    R_FIN,
    R_FLUSH,
    R_MARK
  } ret_e;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = '{default: '0, sel: SEL_MARK};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_STEP;
        end
      end
      S_STEP: begin
        if (!sts_i.held_valid) begin
          cmd_o.load = 1'b1;
          state_d    = S_FIN;
        end else if (sts_i.eq) begin
          if (!sts_i.cnt_ge2 && sts_i.lit_nz) begin
            ret_d   = R_INC;
            state_d = S_LIT_HDR;
          end else begin
            state_d = S_INC;
          end
        end else if (sts_i.cnt_ge2) begin
          ret_d   = R_LOAD;
          state_d = S_RUN_HDR;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.load = 1'b1;
          if (sts_i.push_full) begin
            ret_d   = R_FIN;
            state_d = S_LIT_HDR;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_INC: begin
        cmd_o.inc = 1'b1;
        if (sts_i.cnt_full) begin
          ret_d   = R_CLR;
          state_d = S_RUN_HDR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.fin) begin
          state_d = S_IDLE;
        end else if (!sts_i.held_valid) begin
          state_d = S_FLUSH;
        end else if (sts_i.cnt_ge2) begin
          ret_d   = R_FLUSH;
          state_d = S_RUN_HDR;
        end else begin
          cmd_o.push = 1'b1;
          if (sts_i.push_full) begin
            ret_d   = R_FLUSH;
            state_d = S_LIT_HDR;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        cmd_o.clr = 1'b1;
        if (sts_i.lit_nz) begin
          ret_d   = R_MARK;
          state_d = S_LIT_HDR;
        end else begin
          state_d = S_MARK;
        end
      end
      S_RUN_HDR: begin
        cmd_o.sel = SEL_RUN_HDR;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_RUN_DATA;
        end
      end
      S_RUN_DATA: begin
        cmd_o.sel       = SEL_RUN_DATA;
        cmd_o.item_done = !sts_i.fin;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          case (ret_q)
            R_LOAD:  cmd_o.load = 1'b1;
            R_CLR:   cmd_o.clr = 1'b1;
            default: cmd_o.load = 1'b0;
          endcase
          state_d = (ret_q == R_FLUSH) ? S_FLUSH : S_FIN;
        end
      end
      S_LIT_HDR: begin
        cmd_o.sel = SEL_LIT_HDR;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_LIT_DATA;
        end
      end
      S_LIT_DATA: begin
        cmd_o.sel       = SEL_LIT_DATA;
        // the last data byte ends the request unless a run or the end flush still follows
        cmd_o.item_done = sts_i.lit_last && !sts_i.fin
                          && !((ret_q == R_INC) && sts_i.cnt_full);
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.lit_last) begin
            case (ret_q)
              R_INC:   state_d = S_INC;
              R_FLUSH: state_d = S_FLUSH;
              R_MARK:  state_d = S_MARK;
              default: state_d = S_FIN;
            endcase
          end
        end
      end
      S_MARK: begin
        cmd_o.sel       = SEL_MARK;
        cmd_o.item_done = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= R_FIN;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  `PRLE_ASSERT_IMP(a_emit_needs_room, clk_i, rst_ni, cmd_o.emit, sts_i.out_free)
  `PRLE_ASSERT_IMP(a_mark_only_at_end, clk_i, rst_ni, cmd_o.emit && (cmd_o.sel == SEL_MARK), sts_i.fin)
  `PRLE_ASSERT_IMP(a_push_from_held, clk_i, rst_ni, cmd_o.push, sts_i.held_valid && !sts_i.cnt_ge2)

endmodule

/* src/packbits_run_length_encoder.sv */
// ---------------------------------------------------------------------------
// packbits_run_length_encoder
// streaming packbits encoder, one raw byte per request, code bytes out
// ---------------------------------------------------------------------------
// usage:
//   input channel takes data_byte_i with final_byte_i set on the last byte
//   of a stream; a request is taken when in_valid_i is high and in_stall_o
//   low. output channel gives the code bytes of each request on code_byte_o,
//   taken when out_valid_o is high and out_stall_i low. item_done_o marks
//   the last code byte caused by an input request, stream_done_o the end
//   marker 128 after the last byte. a request that closes no packet gives
//   no output at all.
// timing:
//   one request at a time. a request that gives no output passes through
//   capture, decide, an optional repeat count step and the end check; every
//   code byte it gives leaves through a single output register, and literal
//   bytes come one a cycle from the store's read port while the output does
//   not stall. the last request of a stream also passes the end flush.
// reset:
//   asynchronous, active low; nothing held, no pending literal, output empty.
//   the literal store itself is not cleared.
// stall:
//   a stalled output byte holds; the sequencer waits and the input stays
//   stalled until the request's last byte has entered the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packbits_run_length_encoder #(
  parameter int MAX_LITERAL = prle_pkg::MaxLiteralDef,
  parameter int MAX_RUN     = prle_pkg::MaxRunDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] code_byte_o,
  output logic       item_done_o,
  output logic       stream_done_o
);
  import prle_pkg::*;

  // command and status between sequencer and datapath
  prle_cmd_t cmd;
  prle_sts_t sts;

  // sequencer: decides per request which packets to close and in what order
  prle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: held byte, repeat count, literal store and output register
  prle_dp #(
    .MAX_LITERAL (MAX_LITERAL),
    .MAX_RUN     (MAX_RUN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .final_byte_i  (final_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_byte_o   (code_byte_o),
    .item_done_o   (item_done_o),
    .stream_done_o (stream_done_o)
  );

endmodule

/* sim/packbits_run_length_encoder_tb.sv */
// ---------------------------------------------------------------------------
// packbits_run_length_encoder_tb
// drives byte streams into the packbits encoder and checks every code byte.
// a scoreboard class keeps its own copy of the encoder state. it works out
// the code bytes that each accepted request should give and compares them
// in order with what leaves the output channel. a short directed part comes
// first, then random streams built from runs, literals and noisy stretches.
// both channels idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packbits_run_length_encoder_tb;

  localparam int LitLimit   = prle_pkg::MaxLiteralDef;
  localparam int RunLimit   = prle_pkg::MaxRunDef;
  localparam int CycleLimit = 10000000;

  // -------------------------------------------------------------------------
  // expected code bytes, worked out from a shadow copy of the encoder state
  // -------------------------------------------------------------------------
  class packbits_scoreboard;
    typedef struct packed {
      logic [7:0] code;
      logic       item_done;
      logic       stream_done;
    } code_t;

    code_t      expected_codes[$];
    code_t      request_codes[$];
    bit [7:0]   held_byte;
    bit         held_valid;
    int         repeat_count;
    bit [7:0]   literal_bytes[LitLimit];
    int         literal_count;
    int         errors = 0;

    function void put_code(input logic [7:0] value, input logic stream_end);
      code_t c;
      c.code        = value;
      c.item_done   = 1'b0;
      c.stream_done = stream_end;
      request_codes = {request_codes, c};
    endfunction

    function void flush_literal();
      if (literal_count == 0) return;
      put_code(8'(literal_count - 1), 1'b0);
      for (int k = 0; k < literal_count; k++) put_code(literal_bytes[k], 1'b0);
      literal_count = 0;
    endfunction

    function void push_literal(input logic [7:0] value);
      if (literal_count < LitLimit) begin
        literal_bytes[literal_count] = value;
        literal_count++;
      end
      if (literal_count >= LitLimit) flush_literal();
    endfunction

    // run header is 257 minus the count, taken mod 256
    function void emit_run();
      int hdr;
      hdr = 257 - repeat_count;
      put_code(hdr[7:0], 1'b0);
      put_code(held_byte, 1'b0);
    endfunction

    function void place_held();
      if (repeat_count >= 2) emit_run();
      else push_literal(held_byte);
    endfunction

    // an accepted request: advance the shadow state, queue its code bytes
    function void note_request(input logic [7:0] data, input logic fin);
      request_codes.delete();
      if (!held_valid) begin
        held_byte    = data;
        held_valid   = 1'b1;
        repeat_count = 1;
      end else if (data == held_byte) begin
        if (repeat_count <= 1) flush_literal();
        repeat_count++;
        // long run closes at the limit and the next byte starts afresh
        if (repeat_count >= RunLimit) begin
          emit_run();
          held_valid   = 1'b0;
          repeat_count = 0;
        end
      end else begin
        place_held();
        held_byte    = data;
        repeat_count = 1;
      end
      if (fin) begin
        if (held_valid) place_held();
        held_valid   = 1'b0;
        held_byte    = 8'h00;
        repeat_count = 0;
        flush_literal();
        put_code(prle_pkg::MarkByte, 1'b1);
      end
      if (request_codes.size() > 0) begin
        request_codes[request_codes.size() - 1].item_done = 1'b1;
      end
      expected_codes = {expected_codes, request_codes};
    endfunction

    function void check_result(input logic [7:0] code, input logic idone,
                               input logic sdone);
      code_t exp_code;
      if (expected_codes.size() == 0) begin
        $error("code_byte %02h arrived with nothing expected", code);
        errors++;
        return;
      end
      exp_code = expected_codes.pop_front();
      if (code !== exp_code.code) begin
        $error("code_byte: expected %02h, got %02h", exp_code.code, code);
        errors++;
      end
      if (idone !== exp_code.item_done) begin
        $error("item_done: expected %0b, got %0b", exp_code.item_done, idone);
        errors++;
      end
      if (sdone !== exp_code.stream_done) begin
        $error("stream_done: expected %0b, got %0b", exp_code.stream_done, sdone);
        errors++;
      end
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // block under test
  // -------------------------------------------------------------------------
  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] code_byte_o;
  logic       item_done_o;
  logic       stream_done_o;

  packbits_run_length_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_byte_o  (code_byte_o),
    .item_done_o  (item_done_o),
    .stream_done_o(stream_done_o)
  );

  packbits_scoreboard sb = new();

  logic [7:0] stream_bytes[$];  // raw bytes of the stream being sent
  bit         calm;             // no idling on either side while set
  int         stall_left = 0;
  int         cycle_count = 0;

  always #4 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // output side: random stall bursts, off during calm stretches
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (rst_ni && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // every code byte taken on the output channel goes to the scoreboard;
  // values read here are the ones present at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(code_byte_o, item_done_o, stream_done_o);
    end
  end

  // watchdog against a hung block
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one request; an idle gap may come first, then valid holds until taken
  task automatic send_request(input logic [7:0] data, input logic fin);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= data;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(data, fin);
  endtask

  // the whole stream, final flag on its last byte
  task automatic send_stream();
    calm = ($urandom_range(0, 4) == 0);
    foreach (stream_bytes[i]) send_request(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  // random stream from segments: short runs, literals with no equal
  // neighbours, noise from a two-value alphabet, long literals and long runs;
  // the first two streams open with a long run and a long literal in turn, unless drawn as a single byte
  task automatic build_stream(input int idx);
    int         nseg;
    int         kind;
    int         len;
    logic [7:0] b;
    logic [7:0] base;
    stream_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      b = 8'($urandom_range(0, 255));
      stream_bytes = {stream_bytes, b};
      return;
    end
    nseg = $urandom_range(1, 6);
    for (int s = 0; s < nseg; s++) begin
      kind = $urandom_range(0, 99);
      if (s == 0 && idx == 0) kind = 99;
      if (s == 0 && idx == 1) kind = 92;
      if (kind < 40) begin
        len = $urandom_range(2, 5);
        b = 8'($urandom_range(0, 255));
        repeat (len) stream_bytes = {stream_bytes, b};
      end else if (kind < 75 || (kind >= 90 && kind < 95)) begin
        len = (kind < 75) ? $urandom_range(1, 6) : $urandom_range(33, 40);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if (stream_bytes.size() > 0 && b == stream_bytes[$]) b = b ^ 8'h01;
          stream_bytes = {stream_bytes, b};
        end
      end else if (kind < 90) begin
        len = $urandom_range(1, 8);
        base = 8'($urandom_range(0, 255));
        repeat (len) begin
          b = base ^ 8'($urandom_range(0, 1));
          stream_bytes = {stream_bytes, b};
        end
      end else begin
        len = (idx == 0) ? 129 : $urandom_range(127, 131);
        b = 8'($urandom_range(0, 255));
        repeat (len) stream_bytes = {stream_bytes, b};
      end
    end
  endtask

  initial begin
    int random_items;
    int streams;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    final_byte_i = 1'b0;
    calm         = 1'b1;
    random_items = 0;
    streams      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone final byte at the low extreme
    stream_bytes = '{8'h00};
    send_stream();
    // run of two that ends the stream, high extreme
    stream_bytes = '{8'hFF, 8'hFF};
    send_stream();
    // run of two between literals, final byte differs from the held one
    stream_bytes = '{8'h01, 8'h80, 8'h80, 8'h7F, 8'hFE, 8'hFE, 8'h55, 8'hAA};
    send_stream();
    // run of three, then a final byte that completes a run of two
    stream_bytes = '{8'h11, 8'h11, 8'h11, 8'h22, 8'h22};
    send_stream();

    // random streams until enough requests have gone in
    while (random_items < 100 || streams < 2) begin
      build_stream(streams);
      random_items += stream_bytes.size();
      send_stream();
      streams++;
    end
    in_valid_i <= 1'b0;

    // drain, then keep watching to catch stray output
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
